@@ hdl/tun_pkg.sv @@
// Shared constants, types and helpers of the triangle unit normal pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package tun_pkg;

    localparam int CW = 24;                     // coordinate width, Q8.16
    localparam int NF = 14;                     // fraction bits of the normal
    localparam int OW = 16;                     // output component width
    localparam int ES = (CW > 30) ? (CW - 30) : 0;
    localparam int CWP1 = CW + 1;
    localparam int EW = CW + 1 - ES;            // edge width
    localparam int PW = 2 * EW;                 // product width
    localparam int NW = PW + 1;                 // cross component width
    localparam int MW = 2 * EW;                 // cross magnitude width
    localparam int BLW = $clog2(MW + 1);        // bit length of a magnitude
    localparam int SW = 31;                     // scaled magnitude width
    localparam int SHW = $clog2(MW + SW + 1);
    localparam int SQW = 2 * SW;                // square width
    localparam int RTW = 64;                    // square root datapath width
    localparam int SQ_STEPS = RTW / 2;
    localparam int LW = SW + 1;                 // length width
    localparam int QW = NF + 1;                 // quotient width
    localparam int NUMW = LW + NF;              // dividend width
    localparam int XW = (QW > OW) ? QW : OW;

    localparam logic [CW:0] EBIAS = CWP1'((64'd1 << ES) - 64'd1);
    localparam logic [QW-1:0] QSAT = QW'(1) << NF;

    typedef struct packed {
        logic [2:0][SW-1:0] mag;
        logic [2:0]         neg;
        logic               degen;
    } t_side;

    // Edge difference, truncated toward zero when the coordinates are wide.
    function automatic logic signed [EW-1:0] edge_of(input logic signed [CW-1:0] t,
                                                     input logic signed [CW-1:0] f);
        logic signed [CW:0] d;
        logic signed [CW:0] d2;
        d = {t[CW-1], t} - {f[CW-1], f};
        d2 = d + (d[CW] ? EBIAS : '0);
        return d2[CW:ES];
    endfunction

endpackage
`default_nettype wire

@@ hdl/tun_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on tun_pkg; carries a sideband struct alongside the data.
`default_nettype none
module tun_isqrt import tun_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [RTW-1:0]   i_s,
    input  wire t_side            i_side,
    output logic                  o_vld,
    output logic [RTW-1:0]        o_root,
    output t_side                 o_side
);

    logic [RTW-1:0] r_rem  [SQ_STEPS];
    logic [RTW-1:0] r_root [SQ_STEPS];
    logic           r_vld  [SQ_STEPS];
    t_side          r_side [SQ_STEPS];

    genvar g;
    generate
        for (g = 0; g < SQ_STEPS; g++) begin : g_step
            localparam logic [RTW-1:0] BITV = RTW'(1) << (RTW - 2 - 2 * g);
            logic [RTW-1:0] p_rem, p_root, n_rem, n_root, trial;
            logic           p_vld;
            t_side          p_side;

            if (g == 0) begin : g_first
                assign p_rem  = i_s;
                assign p_root = '0;
                assign p_vld  = i_vld;
                assign p_side = i_side;
            end else begin : g_next
                assign p_rem  = r_rem[g-1];
                assign p_root = r_root[g-1];
                assign p_vld  = r_vld[g-1];
                assign p_side = r_side[g-1];
            end

            always_comb begin
                trial = p_root + BITV;
                if (p_rem >= trial) begin
                    n_rem  = p_rem - trial;
                    n_root = (p_root >> 1) + BITV;
                end else begin
                    n_rem  = p_rem;
                    n_root = p_root >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g]  <= n_rem;
                    r_root[g] <= n_root;
                    r_side[g] <= p_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[SQ_STEPS-1];
    assign o_root = r_root[SQ_STEPS-1];
    assign o_side = r_side[SQ_STEPS-1];

endmodule
`default_nettype wire

@@ hdl/tun_div.sv @@
// Pipelined restoring divider for the three normal components, one quotient
// bit per stage with rounding folded into the dividend. Depends on tun_pkg.
`default_nettype none
module tun_div import tun_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire logic [LW-1:0]    i_len,
    input  wire t_side            i_side,
    output logic                  o_vld,
    output logic [2:0][QW-1:0]    o_q,
    output t_side                 o_side
);

    logic [2:0][NUMW-1:0] r_rem [QW];
    logic [2:0][QW-1:0]   r_q   [QW];
    logic [LW-1:0]        r_len [QW];
    logic                 r_vld [QW];
    t_side                r_side[QW];

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_step
            logic [2:0][NUMW-1:0] p_rem, n_rem;
            logic [2:0][QW-1:0]   p_q, n_q;
            logic [LW-1:0]        p_len;
            logic                 p_vld;
            t_side                p_side;
            logic [NUMW-1:0]      dvs;

            if (g == 0) begin : g_first
                // Dividend is mag * 2^NF plus half the length for rounding.
                for (genvar k = 0; k < 3; k++) begin : g_num
                    assign p_rem[k] = (NUMW'(i_side.mag[k]) << NF) + NUMW'(i_len >> 1);
                end
                assign p_q    = '0;
                assign p_len  = i_len;
                assign p_vld  = i_vld;
                assign p_side = i_side;
            end else begin : g_next
                assign p_rem  = r_rem[g-1];
                assign p_q    = r_q[g-1];
                assign p_len  = r_len[g-1];
                assign p_vld  = r_vld[g-1];
                assign p_side = r_side[g-1];
            end

            always_comb begin
                dvs = NUMW'(p_len) << (NF - g);
                for (int k = 0; k < 3; k++) begin
                    if (p_rem[k] >= dvs) begin
                        n_rem[k] = p_rem[k] - dvs;
                        n_q[k]   = {p_q[k][QW-2:0], 1'b1};
                    end else begin
                        n_rem[k] = p_rem[k];
                        n_q[k]   = {p_q[k][QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (i_en) begin
                    r_vld[g] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g]  <= n_rem;
                    r_q[g]    <= n_q;
                    r_len[g]  <= p_len;
                    r_side[g] <= p_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[QW-1];
    assign o_q    = r_q[QW-1];
    assign o_side = r_side[QW-1];

endmodule
`default_nettype wire

@@ hdl/triangle_unit_normal_unit.sv @@
// Unit face normal of a triangle: A, B, C in Q8.16 in, unit normal in Q2.14 out.
// Depends on tun_pkg, tun_isqrt and tun_div.
//
// Input channel: i_valid with the nine vertex coordinates; the block drives
// o_stall. An item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid with normal_x/y/z and the degenerate flag; the
// receiver drives i_stall. A result is taken when o_valid is high and i_stall
// is low.
// Throughput is one triangle per cycle while i_stall does not hold the pipeline.
// The pipeline is eight stages of edge, cross product, scaling and sum of
// squares, one stage per root bit of the 64-bit square root, one stage per
// quotient bit of the three-lane divider, and the output register.
// The whole pipeline advances together; when the result register holds an
// item and i_stall is high, every stage holds and o_stall is raised.
// A zero cross product gives a zero normal with degenerate set.
// Reset (synchronous, active low) clears every valid bit; data is not reset.
`default_nettype none
module triangle_unit_normal_unit import tun_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic signed [CW-1:0]  i_a_x,
    input  wire logic signed [CW-1:0]  i_a_y,
    input  wire logic signed [CW-1:0]  i_a_z,
    input  wire logic signed [CW-1:0]  i_b_x,
    input  wire logic signed [CW-1:0]  i_b_y,
    input  wire logic signed [CW-1:0]  i_b_z,
    input  wire logic signed [CW-1:0]  i_c_x,
    input  wire logic signed [CW-1:0]  i_c_y,
    input  wire logic signed [CW-1:0]  i_c_z,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [OW-1:0]       o_normal_x,
    output logic signed [OW-1:0]       o_normal_y,
    output logic signed [OW-1:0]       o_normal_z,
    output logic                       o_degenerate
);

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 1: edges.
    logic                   r1_vld;
    logic signed [EW-1:0]   r1_e1 [3];
    logic signed [EW-1:0]   r1_e2 [3];
    // Stage 2: products.
    logic                   r2_vld;
    logic signed [PW-1:0]   r2_p  [6];
    // Stage 3: cross components as sign and magnitude.
    logic                   r3_vld;
    logic [2:0][MW-1:0]     r3_mag;
    logic [2:0]             r3_neg;
    // Stage 4: largest magnitude.
    logic                   r4_vld;
    logic [2:0][MW-1:0]     r4_mag;
    logic [2:0]             r4_neg;
    logic [MW-1:0]          r4_m;
    // Stage 5: bit length.
    logic                   r5_vld;
    logic [2:0][MW-1:0]     r5_mag;
    logic [2:0]             r5_neg;
    logic [BLW-1:0]         r5_bl;
    logic                   r5_degen;
    // Stage 6: scaled magnitudes.
    logic                   r6_vld;
    t_side                  r6_side;
    // Stage 7: squares.
    logic                   r7_vld;
    logic [SQW-1:0]         r7_sq [3];
    t_side                  r7_side;
    // Stage 8: sum of squares.
    logic                   r8_vld;
    logic [RTW-1:0]         r8_s;
    t_side                  r8_side;

    logic signed [NW-1:0]   n3_n  [3];
    logic [NW-1:0]          n3_abs[3];
    logic [MW-1:0]          n4_m;
    logic [BLW-1:0]         n5_bl;
    logic [SHW-1:0]         n6_blx;
    logic [MW+SW-1:0]       n6_w  [3];
    logic [2:0][SW-1:0]     n6_mag;

    always_comb begin
        n3_n[0] = {r2_p[0][PW-1], r2_p[0]} - {r2_p[1][PW-1], r2_p[1]};
        n3_n[1] = {r2_p[2][PW-1], r2_p[2]} - {r2_p[3][PW-1], r2_p[3]};
        n3_n[2] = {r2_p[4][PW-1], r2_p[4]} - {r2_p[5][PW-1], r2_p[5]};
        for (int k = 0; k < 3; k++) begin
            n3_abs[k] = n3_n[k][NW-1] ? -n3_n[k] : n3_n[k];
        end
    end

    always_comb begin
        n4_m = r3_mag[0];
        if (r3_mag[1] > n4_m) n4_m = r3_mag[1];
        if (r3_mag[2] > n4_m) n4_m = r3_mag[2];
    end

    // Bit length of the largest magnitude: highest set bit wins.
    always_comb begin
        n5_bl = '0;
        for (int i = 0; i < MW; i++) begin
            if (r4_m[i]) n5_bl = BLW'(i + 1);
        end
    end

    // Bring the top bit of the largest magnitude to bit SW-1.
    always_comb begin
        n6_blx = SHW'(r5_bl);
        for (int k = 0; k < 3; k++) begin
            if (n6_blx > SHW'(SW)) begin
                n6_w[k] = (MW+SW)'(r5_mag[k]) >> (n6_blx - SHW'(SW));
            end else begin
                n6_w[k] = (MW+SW)'(r5_mag[k]) << (SHW'(SW) - n6_blx);
            end
            n6_mag[k] = n6_w[k][SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_e1[0] <= edge_of(i_b_x, i_a_x);
            r1_e1[1] <= edge_of(i_b_y, i_a_y);
            r1_e1[2] <= edge_of(i_b_z, i_a_z);
            r1_e2[0] <= edge_of(i_c_x, i_a_x);
            r1_e2[1] <= edge_of(i_c_y, i_a_y);
            r1_e2[2] <= edge_of(i_c_z, i_a_z);

            r2_p[0] <= r1_e1[1] * r1_e2[2];
            r2_p[1] <= r1_e1[2] * r1_e2[1];
            r2_p[2] <= r1_e1[2] * r1_e2[0];
            r2_p[3] <= r1_e1[0] * r1_e2[2];
            r2_p[4] <= r1_e1[0] * r1_e2[1];
            r2_p[5] <= r1_e1[1] * r1_e2[0];

            for (int k = 0; k < 3; k++) begin
                r3_mag[k] <= n3_abs[k][MW-1:0];
                r3_neg[k] <= n3_n[k][NW-1];
            end

            r4_mag <= r3_mag;
            r4_neg <= r3_neg;
            r4_m   <= n4_m;

            r5_mag   <= r4_mag;
            r5_neg   <= r4_neg;
            r5_bl    <= n5_bl;
            r5_degen <= (r4_m == '0);

            r6_side.mag   <= n6_mag;
            r6_side.neg   <= r5_neg;
            r6_side.degen <= r5_degen;

            for (int k = 0; k < 3; k++) begin
                r7_sq[k] <= r6_side.mag[k] * r6_side.mag[k];
            end
            r7_side <= r6_side;

            r8_s    <= RTW'(r7_sq[0]) + RTW'(r7_sq[1]) + RTW'(r7_sq[2]);
            r8_side <= r7_side;
        end
    end

    logic               sq_vld;
    logic [RTW-1:0]     sq_root;
    t_side              sq_side;

    tun_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r8_vld),
        .i_s     (r8_s),
        .i_side  (r8_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    logic               dv_vld;
    logic [2:0][QW-1:0] dv_q;
    t_side              dv_side;

    tun_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_len   (sq_root[LW-1:0]),
        .i_side  (sq_side),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // Saturate, restore the sign, keep the low output bits and zero a degenerate result.
    logic [QW-1:0]      n_sat [3];
    logic [XW-1:0]      n_ext [3];
    logic [2:0][OW-1:0] n_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sat[k] = (dv_q[k] > QSAT) ? QSAT : dv_q[k];
            n_ext[k] = dv_side.neg[k] ? -XW'(n_sat[k]) : XW'(n_sat[k]);
            n_out[k] = dv_side.degen ? '0 : n_ext[k][OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_normal_x   <= n_out[0];
            o_normal_y   <= n_out[1];
            o_normal_z   <= n_out[2];
            o_degenerate <= dv_side.degen;
        end
    end

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_normal_x == '0 && o_normal_y == '0
                                    && o_normal_z == '0)
        else $error("degenerate result with nonzero normal");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_normal_x <= $signed(OW'(QSAT))
            && o_normal_x >= -$signed(OW'(QSAT)) && o_normal_y <= $signed(OW'(QSAT))
            && o_normal_y >= -$signed(OW'(QSAT)) && o_normal_z <= $signed(OW'(QSAT))
            && o_normal_z >= -$signed(OW'(QSAT)))
        else $error("normal component outside unit range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
